// ----- rtl/nac_pkg.sv -----
// Shared types and constants of the N-dimensional index/offset converter.
// Depends on nothing; every other file refers to it by scoped names.
package nac_pkg;

  localparam int NUM_FIELD_DIMS = 4;
  localparam int COORD_W        = 16;
  localparam int LIN_W          = 64;
  localparam int STATUS_W       = 3;
  localparam int RANK_W         = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY_SHAPE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANK_ZERO    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANK_MISMATCH= 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_BOUNDS= 3'd4;
  localparam logic [STATUS_W-1:0] ST_OFFSET_RANGE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_RANK        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_LAST = 3'd4;

  localparam logic OP_TO_OFFSET = 1'b0;
  localparam logic OP_TO_INDEX  = 1'b1;

  typedef struct packed {
    logic                op;
    logic [RANK_W-1:0]   index_rank;
    logic [COORD_W-1:0]  coord_0;
    logic [COORD_W-1:0]  coord_1;
    logic [COORD_W-1:0]  coord_2;
    logic [COORD_W-1:0]  coord_3;
    logic [LIN_W-1:0]    linear_in;
  } in_item_t;

  typedef struct packed {
    logic [LIN_W-1:0]    linear_out;
    logic [COORD_W-1:0]  out_coord_0;
    logic [COORD_W-1:0]  out_coord_1;
    logic [COORD_W-1:0]  out_coord_2;
    logic [COORD_W-1:0]  out_coord_3;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // Work record carried down the pipeline. acc holds the running sum for
  // index to offset and the running remainder for offset to index.
  typedef struct packed {
    logic                                     op;
    logic [STATUS_W-1:0]                      status;
    logic [LIN_W-1:0]                         acc;
    logic [NUM_FIELD_DIMS-1:0][COORD_W-1:0]   coord;
  } stage_t;

endpackage

// ----- rtl/nac_stream_if.sv -----
// Valid/ready channel carrying one item of payload type T.
// Depends on nac_pkg for the payload types used by the top level.
interface nac_stream_if #(
  parameter type T = nac_pkg::in_item_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/nac_shape.sv -----
// Shape registers and the stride/size sequencer of the converter.
// Depends on nac_pkg; each step uses two 32x32 multiplies, in states SEQ_LO and SEQ_HI.
module nac_shape #(
  parameter int MAX_RANK    = 4,
  parameter int EXTENT_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [nac_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [nac_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic                                  busy_o,
  output logic [nac_pkg::RANK_W-1:0]            rank_o,
  output logic [EXTENT_BITS-1:0]                ext_o [nac_pkg::NUM_FIELD_DIMS],
  output logic [nac_pkg::LIN_W-1:0]             strides_o [MAX_RANK],
  output logic [nac_pkg::LIN_W-1:0]             size_o
);

  localparam int ARR = (MAX_RANK > nac_pkg::NUM_FIELD_DIMS) ? MAX_RANK
                                                            : nac_pkg::NUM_FIELD_DIMS;
  localparam int IW  = $clog2(ARR);

  localparam logic [1:0] SEQ_IDLE = 2'd0;
  localparam logic [1:0] SEQ_LO   = 2'd1;
  localparam logic [1:0] SEQ_HI   = 2'd2;

  logic [nac_pkg::RANK_W-1:0] rank_q;
  logic [EXTENT_BITS-1:0]     ext_q [nac_pkg::NUM_FIELD_DIMS];
  logic [EXTENT_BITS-1:0]     ext_full [ARR];
  logic [nac_pkg::LIN_W-1:0]  stride_q [ARR];
  logic [nac_pkg::LIN_W-1:0]  size_q;
  logic [nac_pkg::LIN_W-1:0]  cur_q;
  logic [nac_pkg::LIN_W-1:0]  plo_q;
  logic [IW-1:0]              i_q;
  logic [1:0]                 state_q;

  logic [nac_pkg::RANK_W-1:0] rank_nx;
  logic                       rank_ok;
  logic                       restart;
  logic [31:0]                ext32;
  logic [31:0]                phi;
  logic [nac_pkg::LIN_W-1:0]  prod;

  for (genvar d = 0; d < ARR; d++) begin : g_ext
    if (d < nac_pkg::NUM_FIELD_DIMS) begin : g_fld
      assign ext_full[d] = ext_q[d];
    end else begin : g_none
      assign ext_full[d] = '0;
    end
  end

  for (genvar d = 0; d < MAX_RANK; d++) begin : g_str
    assign strides_o[d] = stride_q[d];
  end

  assign rank_nx = (cfg_idx_i == nac_pkg::CFG_RANK) ? cfg_data_i[nac_pkg::RANK_W-1:0] : rank_q;
  assign rank_ok = (rank_nx != '0) && (32'(rank_nx) <= 32'(MAX_RANK));
  assign restart = cfg_we_i && (cfg_idx_i <= nac_pkg::CFG_EXTENT_LAST);

  assign ext32 = 32'(ext_full[i_q]);
  assign phi   = cur_q[63:32] * ext32;
  assign prod  = plo_q + {phi, 32'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= '0;
      ext_q   <= '{default: '0};
      stride_q <= '{default: '0};
      size_q  <= '0;
      state_q <= SEQ_IDLE;
      cur_q   <= '0;
      plo_q   <= '0;
      i_q     <= '0;
    end else if (restart) begin
      if (cfg_idx_i == nac_pkg::CFG_RANK) begin
        rank_q <= rank_nx;
      end else begin
        ext_q[2'(cfg_idx_i - nac_pkg::CFG_EXTENT_0)] <= EXTENT_BITS'(cfg_data_i);
      end
      // With a valid rank the innermost stride is one; outer ones are rebuilt, the rest are zero.
      for (int d = 0; d < ARR; d++) begin
        stride_q[d] <= (rank_ok && (d == int'(rank_nx) - 1)) ? 64'd1 : 64'd0;
      end
      size_q   <= '0;
      if (rank_ok) begin
        cur_q   <= 64'd1;
        i_q     <= IW'(rank_nx - 3'd1);
        state_q <= SEQ_LO;
      end else begin
        state_q <= SEQ_IDLE;
      end
    end else begin
      case (state_q)
        SEQ_LO: begin
          plo_q   <= {32'b0, cur_q[31:0]} * {32'b0, ext32};
          state_q <= SEQ_HI;
        end
        SEQ_HI: begin
          cur_q <= prod;
          if (i_q == '0) begin
            size_q  <= prod;
            state_q <= SEQ_IDLE;
          end else begin
            stride_q[i_q - 1'b1] <= prod;
            i_q     <= i_q - 1'b1;
            state_q <= SEQ_LO;
          end
        end
        default: state_q <= SEQ_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != SEQ_IDLE);
  assign rank_o = rank_q;
  assign ext_o  = ext_q;
  assign size_o = size_q;

endmodule

// ----- rtl/nac_step.sv -----
// One pipeline stage: one digit bit of a shift-add multiply or restoring divide.
// Depends on nac_pkg for the stage record.
module nac_step #(
  parameter int DIM     = 0,
  parameter int BIT     = 0,
  parameter int SHIFT_W = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  nac_pkg::stage_t            data_i,
  input  logic [nac_pkg::LIN_W-1:0]  stride_i,
  output logic                       valid_o,
  output nac_pkg::stage_t            data_o
);

  localparam int W = nac_pkg::LIN_W + SHIFT_W;

  logic            valid_q;
  nac_pkg::stage_t data_q;
  nac_pkg::stage_t data_d;
  logic [W-1:0]    shifted;
  logic [W-1:0]    acc_w;

  assign shifted = {{SHIFT_W{1'b0}}, stride_i} << BIT;
  assign acc_w   = {{SHIFT_W{1'b0}}, data_i.acc};

  always_comb begin
    data_d = data_i;
    if (data_i.status == nac_pkg::ST_OK) begin
      if (data_i.op == nac_pkg::OP_TO_OFFSET) begin
        if (data_i.coord[DIM][BIT]) begin
          data_d.acc = data_i.acc + shifted[nac_pkg::LIN_W-1:0];
        end
      end else if (stride_i != '0 && acc_w >= shifted) begin
        // Quotient bit is one: take this multiple of the stride off.
        data_d.acc = data_i.acc - shifted[nac_pkg::LIN_W-1:0];
        data_d.coord[DIM][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/nd_array_offset_index_converter_unit.sv -----
// Row-major N-dimensional index <-> linear offset converter.
// An input register feeds one stage per digit bit of the shift-add / restoring-divide
// chain. Throughput: one item per cycle while out_o is ready and no stride rebuild runs.
// A rank or extent write with a valid rank makes the sequencer rebuild strides and size;
// no item is accepted meanwhile. Reset clears shape registers, strides and all valid bits.
module nd_array_offset_index_converter_unit #(
  parameter int MAX_RANK    = 4,
  parameter int EXTENT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  nac_stream_if.sink                         in_i,
  nac_stream_if.source                       out_o,
  input  logic                               cfg_we_i,
  input  logic [nac_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [nac_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int ND = (MAX_RANK < nac_pkg::NUM_FIELD_DIMS) ? MAX_RANK
                                                           : nac_pkg::NUM_FIELD_DIMS;
  localparam int DB = (EXTENT_BITS < nac_pkg::COORD_W) ? EXTENT_BITS : nac_pkg::COORD_W;
  localparam int NS = ND * DB;

  logic                          busy;
  logic [nac_pkg::RANK_W-1:0]    rank;
  logic [EXTENT_BITS-1:0]        ext [nac_pkg::NUM_FIELD_DIMS];
  logic [nac_pkg::LIN_W-1:0]     strides [MAX_RANK];
  logic [nac_pkg::LIN_W-1:0]     size;

  logic                          vld [NS+1];
  nac_pkg::stage_t               stg [NS+1];
  logic                          en  [NS+1];

  nac_pkg::in_item_t             it;
  nac_pkg::stage_t               s0_d;
  logic                          s0_vld_q;
  nac_pkg::stage_t               s0_q;
  logic                          oob;
  nac_pkg::stage_t               last;
  nac_pkg::out_item_t            res;

  nac_shape #(
    .MAX_RANK    (MAX_RANK),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_shape (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (busy),
    .rank_o     (rank),
    .ext_o      (ext),
    .strides_o  (strides),
    .size_o     (size)
  );

  assign it = in_i.data;

  always_comb begin
    s0_d = '0;
    s0_d.op = it.op;
    s0_d.coord[0] = it.coord_0;
    s0_d.coord[1] = it.coord_1;
    s0_d.coord[2] = it.coord_2;
    s0_d.coord[3] = it.coord_3;
    oob = 1'b0;
    for (int d = 0; d < nac_pkg::NUM_FIELD_DIMS; d++) begin
      if (nac_pkg::RANK_W'(d) < rank && 32'(s0_d.coord[d]) >= 32'(ext[d])) begin
        oob = 1'b1;
      end
    end
    if (it.op == nac_pkg::OP_TO_INDEX) begin
      s0_d.acc   = it.linear_in;
      s0_d.coord = '0;
    end
    if (size == '0) begin
      s0_d.status = nac_pkg::ST_EMPTY_SHAPE;
    end else if (it.index_rank == '0) begin
      s0_d.status = nac_pkg::ST_RANK_ZERO;
    end else if (it.index_rank != rank) begin
      s0_d.status = nac_pkg::ST_RANK_MISMATCH;
    end else if (it.op == nac_pkg::OP_TO_OFFSET) begin
      s0_d.status = oob ? nac_pkg::ST_OUT_OF_BOUNDS : nac_pkg::ST_OK;
    end else begin
      s0_d.status = (it.linear_in >= size) ? nac_pkg::ST_OFFSET_RANGE : nac_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en[0]) begin
      s0_vld_q <= in_i.valid && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_i.valid && !busy) begin
      s0_q <= s0_d;
    end
  end

  assign vld[0] = s0_vld_q;
  assign stg[0] = s0_q;

  // A stage loads when it is empty or its successor loads this cycle.
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign en[NS] = !vld[NS] || out_o.ready;

  for (genvar k = 1; k <= NS; k++) begin : g_step
    nac_step #(
      .DIM     ((k - 1) / DB),
      .BIT     (DB - 1 - ((k - 1) % DB)),
      .SHIFT_W (DB)
    ) u_step (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en[k]),
      .valid_i  (vld[k-1]),
      .data_i   (stg[k-1]),
      .stride_i (strides[(k - 1) / DB]),
      .valid_o  (vld[k]),
      .data_o   (stg[k])
    );
  end

  assign in_i.ready = en[0] && !busy;

  assign last = stg[NS];

  always_comb begin
    res = '0;
    res.status = last.status;
    if (last.status == nac_pkg::ST_OK) begin
      if (last.op == nac_pkg::OP_TO_OFFSET) begin
        res.linear_out = last.acc;
      end else begin
        res.out_coord_0 = last.coord[0];
        res.out_coord_1 = last.coord[1];
        res.out_coord_2 = last.coord[2];
        res.out_coord_3 = last.coord[3];
      end
    end
  end

  assign out_o.valid = vld[NS];
  assign out_o.data  = res;

endmodule

// ----- tb/nd_array_offset_index_converter_unit_tb.sv -----
// Testbench for the N-dimensional index/offset converter: drives index and offset
// items through valid/ready channels and checks every result against a local predictor.
// Depends on nac_pkg, nac_stream_if and nd_array_offset_index_converter_unit.
`timescale 1ns / 1ps

module nd_array_offset_index_converter_unit_tb;

  localparam int  PIPE_DRAIN   = 70;
  localparam int  CFG_SETTLE   = 20;
  localparam int  CYCLE_LIMIT  = 2000000;
  localparam logic [nac_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = nac_pkg::CFG_EXTENT_LAST + 3'd1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [nac_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [nac_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  nac_stream_if #(.T(nac_pkg::in_item_t))  in_ch ();
  nac_stream_if #(.T(nac_pkg::out_item_t)) out_ch ();

  nd_array_offset_index_converter_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shape as the block should hold it, with its derived strides and size.
  logic [nac_pkg::RANK_W-1:0]  shape_rank;
  logic [15:0]                 shape_ext[4];
  logic [63:0]                 shape_stride[4];
  logic [63:0]                 shape_size;

  nac_pkg::out_item_t pending_results[$];
  int        failures;
  int        cycles;
  int        hold_req;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    shape_rank = '0;
    for (int d = 0; d < 4; d++) shape_ext[d] = '0;
    failures = 0;
    cycles = 0;
    hold_req = 0;
  end

  function automatic void derive_shape();
    int n;
    n = shape_rank;
    for (int d = 0; d < 4; d++) shape_stride[d] = '0;
    if (n == 0 || n > 4) begin
      shape_size = '0;
    end else begin
      shape_stride[n-1] = 64'd1;
      for (int d = n - 1; d > 0; d--) shape_stride[d-1] = shape_stride[d] * shape_ext[d];
      shape_size = shape_stride[0] * shape_ext[0];
    end
  endfunction

  function automatic nac_pkg::out_item_t convert(nac_pkg::in_item_t it);
    nac_pkg::out_item_t r;
    logic [15:0] c[4];
    logic [15:0] q[4];
    logic [63:0] acc;
    logic [63:0] rem;
    r = '0;
    c[0] = it.coord_0; c[1] = it.coord_1; c[2] = it.coord_2; c[3] = it.coord_3;
    for (int d = 0; d < 4; d++) q[d] = '0;
    if (shape_size == 0) begin
      r.status = nac_pkg::ST_EMPTY_SHAPE;
    end else if (it.index_rank == 0) begin
      r.status = nac_pkg::ST_RANK_ZERO;
    end else if (it.index_rank != shape_rank) begin
      r.status = nac_pkg::ST_RANK_MISMATCH;
    end else if (it.op == nac_pkg::OP_TO_OFFSET) begin
      acc = '0;
      r.status = nac_pkg::ST_OK;
      for (int d = 0; d < shape_rank; d++) begin
        if (c[d] >= shape_ext[d]) begin
          r.status = nac_pkg::ST_OUT_OF_BOUNDS;
          break;
        end
        acc += 64'(c[d]) * shape_stride[d];
      end
      if (r.status == nac_pkg::ST_OK) r.linear_out = acc;
    end else if (it.linear_in >= shape_size) begin
      r.status = nac_pkg::ST_OFFSET_RANGE;
    end else begin
      rem = it.linear_in;
      for (int d = 0; d < shape_rank; d++) begin
        q[d] = 16'(rem / shape_stride[d]);
        rem  = rem % shape_stride[d];
      end
      r.status = nac_pkg::ST_OK;
    end
    r.out_coord_0 = q[0]; r.out_coord_1 = q[1];
    r.out_coord_2 = q[2]; r.out_coord_3 = q[3];
    return r;
  endfunction

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 3);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    nac_pkg::out_item_t want;
    nac_pkg::out_item_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("result item with no expectation waiting");
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got.linear_out != want.linear_out) begin
          $error("linear_out: expected %0d, got %0d", want.linear_out, got.linear_out);
          failures++;
        end
        if (got.out_coord_0 != want.out_coord_0) begin
          $error("out_coord_0: expected %0d, got %0d", want.out_coord_0, got.out_coord_0);
          failures++;
        end
        if (got.out_coord_1 != want.out_coord_1) begin
          $error("out_coord_1: expected %0d, got %0d", want.out_coord_1, got.out_coord_1);
          failures++;
        end
        if (got.out_coord_2 != want.out_coord_2) begin
          $error("out_coord_2: expected %0d, got %0d", want.out_coord_2, got.out_coord_2);
          failures++;
        end
        if (got.out_coord_3 != want.out_coord_3) begin
          $error("out_coord_3: expected %0d, got %0d", want.out_coord_3, got.out_coord_3);
          failures++;
        end
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offers one item and returns at the edge where it is accepted.
  task automatic send_item(nac_pkg::in_item_t it, bit no_gap = 1'b0);
    int gap;
    gap = 0;
    if (!no_gap) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: gap = 0;
        19: gap = $urandom_range(10, 40);
        default: gap = $urandom_range(1, 3);
      endcase
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_results.push_back(convert(it));
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [nac_pkg::CFG_IDX_W-1:0] idx,
                           logic [nac_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == nac_pkg::CFG_RANK) shape_rank = val[nac_pkg::RANK_W-1:0];
    else if (idx <= nac_pkg::CFG_EXTENT_LAST) shape_ext[2'(idx - nac_pkg::CFG_EXTENT_0)] = val;
    derive_shape();
    // Let the stride sequencer finish before anything else happens.
    repeat (CFG_SETTLE) @(posedge clk_i);
  endtask

  task automatic set_shape(int r, int e0, int e1, int e2, int e3);
    drain();
    write_reg(nac_pkg::CFG_EXTENT_0,        16'(e0));
    write_reg(nac_pkg::CFG_EXTENT_0 + 3'd1, 16'(e1));
    write_reg(nac_pkg::CFG_EXTENT_0 + 3'd2, 16'(e2));
    write_reg(nac_pkg::CFG_EXTENT_LAST,     16'(e3));
    write_reg(nac_pkg::CFG_RANK,            16'(r));
  endtask

  function automatic nac_pkg::in_item_t make_item(logic op, int irank, int c0, int c1, int c2,
                                                  int c3, logic [63:0] lin);
    nac_pkg::in_item_t it;
    it.op = op;
    it.index_rank = nac_pkg::RANK_W'(irank);
    it.coord_0 = 16'(c0); it.coord_1 = 16'(c1);
    it.coord_2 = 16'(c2); it.coord_3 = 16'(c3);
    it.linear_in = lin;
    return it;
  endfunction

  // Mostly well-formed requests for the current shape, with some noise.
  function automatic nac_pkg::in_item_t random_item();
    nac_pkg::in_item_t it;
    logic [15:0]       c[4];
    it.op = 1'($urandom_range(0, 1));
    it.index_rank = ($urandom_range(0, 9) < 8) ? shape_rank
                                                : nac_pkg::RANK_W'($urandom_range(0, 7));
    for (int d = 0; d < 4; d++) begin
      if (d < shape_rank && shape_ext[d] != 0 && $urandom_range(0, 9) < 9)
        c[d] = 16'($urandom_range(0, shape_ext[d] - 1));
      else
        c[d] = 16'($urandom);
    end
    it.coord_0 = c[0]; it.coord_1 = c[1]; it.coord_2 = c[2]; it.coord_3 = c[3];
    it.linear_in = {$urandom, $urandom};
    if (shape_size != 0 && $urandom_range(0, 9) < 9) it.linear_in = it.linear_in % shape_size;
    return it;
  endfunction

  task automatic test_reset_shape();
    send_item(make_item(nac_pkg::OP_TO_OFFSET, 1, 0, 0, 0, 0, 0));
    send_item(make_item(nac_pkg::OP_TO_INDEX, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_small_shape();
    set_shape(3, 3, 5, 7, 9);
    send_item(make_item(nac_pkg::OP_TO_OFFSET, 3, 0, 0, 0, 0, 0));
    send_item(make_item(nac_pkg::OP_TO_OFFSET, 3, 2, 4, 6, 0, 0));
    send_item(make_item(nac_pkg::OP_TO_OFFSET, 3, 3, 0, 0, 0, 0));
    send_item(make_item(nac_pkg::OP_TO_OFFSET, 3, 0, 5, 0, 0, 0));
    send_item(make_item(nac_pkg::OP_TO_OFFSET, 3, 0, 0, 65535, 0, 0));
    send_item(make_item(nac_pkg::OP_TO_OFFSET, 0, 1, 1, 1, 0, 0));
    send_item(make_item(nac_pkg::OP_TO_OFFSET, 4, 1, 1, 1, 0, 0));
    send_item(make_item(nac_pkg::OP_TO_INDEX, 3, 0, 0, 0, 0, 0));
    send_item(make_item(nac_pkg::OP_TO_INDEX, 3, 0, 0, 0, 0, 104));
    send_item(make_item(nac_pkg::OP_TO_INDEX, 3, 0, 0, 0, 0, 105));
    send_item(make_item(nac_pkg::OP_TO_INDEX, 3, 0, 0, 0, 0, '1));
    send_item(make_item(nac_pkg::OP_TO_INDEX, 7, 0, 0, 0, 0, 5));
  endtask

  task automatic test_widest_shape();
    set_shape(4, 65535, 65535, 65535, 65535);
    send_item(make_item(nac_pkg::OP_TO_OFFSET, 4, 65534, 65534, 65534, 65534, 0));
    send_item(make_item(nac_pkg::OP_TO_OFFSET, 4, 65535, 65535, 65535, 65535, 0));
    send_item(make_item(nac_pkg::OP_TO_INDEX, 4, 0, 0, 0, 0, shape_size - 1));
    send_item(make_item(nac_pkg::OP_TO_INDEX, 4, 0, 0, 0, 0, shape_size));
    set_shape(1, 65535, 0, 0, 0);
    send_item(make_item(nac_pkg::OP_TO_INDEX, 1, 0, 0, 0, 0, 65534));
  endtask

  task automatic test_empty_shapes();
    set_shape(2, 4, 0, 3, 3);
    send_item(make_item(nac_pkg::OP_TO_OFFSET, 2, 0, 0, 0, 0, 0));
    send_item(make_item(nac_pkg::OP_TO_INDEX, 2, 0, 0, 0, 0, 0));
    set_shape(6, 2, 2, 2, 2);
    send_item(make_item(nac_pkg::OP_TO_INDEX, 6, 0, 0, 0, 0, 0));
    // Writes to unused register indexes must leave the shape alone.
    drain();
    write_reg(CFG_UNUSED_LO, 16'hFFFF);
    write_reg(CFG_UNUSED_LO + 3'd2, 16'hA5A5);
    send_item(make_item(nac_pkg::OP_TO_INDEX, 6, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_shapes();
    int e[4];
    for (int phase = 0; phase < 12; phase++) begin
      for (int d = 0; d < 4; d++)
        e[d] = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 20);
      if (phase == 0) e = '{1, 1, 1, 1};
      if (phase == 1) e = '{65535, 65535, 65535, 65535};
      set_shape((phase < 2) ? 4 : (($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                                 : $urandom_range(1, 4)),
                e[0], e[1], e[2], e[3]);
      repeat (115) send_item(random_item());
    end
  endtask

  task automatic test_backpressure();
    set_shape(3, 16, 9, 11, 0);
    hold_req = 400;
    repeat (120) send_item(random_item(), 1'b1);
    drain();
    repeat (40) send_item(random_item());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    derive_shape();
    test_reset_shape();
    test_small_shape();
    test_widest_shape();
    test_empty_shapes();
    test_random_shapes();
    test_backpressure();
    drain();
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
